### rtl/adtm_pkg.sv
// ============================================================================
// adtm_pkg: shared types and constants
// Command and status bundles between the controller and the datapath of the
// apogee detector, plus fixed field widths.
// ============================================================================
package adtm_pkg;

    // Field widths fixed by the data format
    localparam int ALT_W = 32;
    localparam int THR_W = 16;

    // Apogee threshold after reset: 0.1 m in 1/256 m units, rounded
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd26;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;        // beat accepted: store fused sample
        logic out_plain;   // load result register, no rate
        logic sort_step;   // one odd-even transposition pass
        logic sort_phase;  // 0: even pairs, 1: odd pairs
        logic sum_en;      // add middle entries pairwise
        logic center_en;   // form window center
        logic out_rate;    // load result register with rate
    } adtm_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic last_sample; // next stored sample closes the window
    } adtm_stat_t;

endpackage

### rtl/adtm_if.sv
// ============================================================================
// adtm_if: stream channels of the apogee detector
// Valid/ready channels for sensor samples in and results out.
// ============================================================================
interface adtm_in_if;
    import adtm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [ALT_W-1:0] baro_altitude;
    logic signed [ALT_W-1:0] gps_altitude;
    logic                    gps_fix;

    modport source (output valid, output baro_altitude, output gps_altitude,
                    output gps_fix, input ready);
    modport sink   (input valid, input baro_altitude, input gps_altitude,
                    input gps_fix, output ready);
endinterface

interface adtm_out_if;
    import adtm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [ALT_W-1:0] fused_altitude;
    logic                    rate_valid;
    logic signed [ALT_W-1:0] altitude_rate;
    logic                    apogee_flag;

    modport source (output valid, output fused_altitude, output rate_valid,
                    output altitude_rate, output apogee_flag, input ready);
    modport sink   (input valid, input fused_altitude, input rate_valid,
                    input altitude_rate, input apogee_flag, output ready);
endinterface

### rtl/adtm_ctrl.sv
// ============================================================================
// adtm_ctrl: sequencer of the apogee detector
// Runs the handshakes, steps the sort passes and the center/rate stages,
// and owns the result valid flag.
// ============================================================================
module adtm_ctrl #(
    parameter int WINDOW = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  adtm_pkg::adtm_stat_t  stat,
    output adtm_pkg::adtm_cmd_t   cmd
);
    import adtm_pkg::*;

    localparam int PASS_W = $clog2(WINDOW);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SORT   = 5'b00010,
        ST_SUM    = 5'b00100,
        ST_CENTER = 5'b01000,
        ST_RATE   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [PASS_W-1:0]   pass_reg, pass_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;
    logic                accept;

    // Result register is free when empty or being drained this cycle
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Commands
    always_comb
    begin
        cmd            = '0;
        cmd.load       = accept;
        cmd.out_plain  = accept && !stat.last_sample;
        cmd.sort_step  = (state_reg == ST_SORT);
        cmd.sort_phase = pass_reg[0];
        cmd.sum_en     = (state_reg == ST_SUM);
        cmd.center_en  = (state_reg == ST_CENTER);
        cmd.out_rate   = (state_reg == ST_RATE) && out_free;
    end

    // Next state and pass counter
    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && stat.last_sample)
                begin
                    state_next = ST_SORT;
                    pass_next  = '0;
                end
            end
            ST_SORT:
            begin
                if (pass_reg == PASS_W'(WINDOW - 1))
                begin
                    state_next = ST_SUM;
                    pass_next  = '0;
                end
                else
                begin
                    pass_next = pass_reg + PASS_W'(1);
                end
            end
            ST_SUM:    state_next = ST_CENTER;
            ST_CENTER: state_next = ST_RATE;
            ST_RATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_plain || cmd.out_rate)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/adtm_dp.sv
// ============================================================================
// adtm_dp: datapath of the apogee detector
// Sensor fusion, sample window with in-place odd-even transposition sort,
// trimmed center, rate with saturation, threshold compare, result register.
// ============================================================================
module adtm_dp #(
    parameter int WINDOW = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  adtm_pkg::adtm_cmd_t               cmd,
    output adtm_pkg::adtm_stat_t              stat,
    input  logic signed [adtm_pkg::ALT_W-1:0] baro_altitude,
    input  logic signed [adtm_pkg::ALT_W-1:0] gps_altitude,
    input  logic                              gps_fix,
    input  logic                              cfg_wr_en,
    input  logic [adtm_pkg::THR_W-1:0]        cfg_wr_data,
    output logic signed [adtm_pkg::ALT_W-1:0] fused_altitude,
    output logic                              rate_valid,
    output logic signed [adtm_pkg::ALT_W-1:0] altitude_rate,
    output logic                              apogee_flag
);
    import adtm_pkg::*;

    localparam int CNT_W = $clog2(WINDOW);
    localparam int LO    = WINDOW / 2 - 2;

    logic signed [ALT_W-1:0] win_reg [WINDOW];
    logic signed [ALT_W-1:0] win_next [WINDOW];
    logic [CNT_W-1:0]        count_reg;
    logic [THR_W-1:0]        thr_reg;
    logic signed [ALT_W-1:0] hold_reg;
    logic signed [ALT_W:0]   pair_a_reg, pair_b_reg;
    logic signed [ALT_W-1:0] center_reg;
    logic signed [ALT_W-1:0] prev_reg;
    logic signed [ALT_W-1:0] fused_out_reg;
    logic                    rate_valid_reg;
    logic signed [ALT_W-1:0] rate_out_reg;
    logic                    apogee_reg;

    logic                    baro_ok;
    logic signed [ALT_W:0]   sensor_sum;
    logic signed [ALT_W-1:0] fused_now;
    logic signed [ALT_W+1:0] total;
    logic signed [ALT_W:0]   diff;
    logic signed [ALT_W-1:0] rate_sat;
    logic                    apogee_now;

    assign stat.last_sample = (count_reg == CNT_W'(WINDOW - 1));

    // Fusion: floor mean when both good, else the good one, else zero
    assign baro_ok    = (baro_altitude != '0);
    assign sensor_sum = {baro_altitude[ALT_W-1], baro_altitude}
                      + {gps_altitude[ALT_W-1], gps_altitude};
    always_comb
    begin
        if (baro_ok && gps_fix)
        begin
            fused_now = sensor_sum[ALT_W:1];
        end
        else if (baro_ok)
        begin
            fused_now = baro_altitude;
        end
        else if (gps_fix)
        begin
            fused_now = gps_altitude;
        end
        else
        begin
            fused_now = '0;
        end
    end

    // Window: shift in on a new sample, compare-swap pairs while sorting
    always_comb
    begin
        win_next = win_reg;
        if (cmd.load)
        begin
            for (int i = 0; i < WINDOW - 1; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[WINDOW-1] = fused_now;
        end
        else if (cmd.sort_step)
        begin
            for (int i = 0; i < WINDOW - 1; i++)
            begin
                if ((1'(i) == cmd.sort_phase) && (win_reg[i] > win_reg[i + 1]))
                begin
                    win_next[i]     = win_reg[i + 1];
                    win_next[i + 1] = win_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    // Center = floor of the middle four over four
    assign total = {pair_a_reg[ALT_W], pair_a_reg} + {pair_b_reg[ALT_W], pair_b_reg};

    // Rate against previous center, saturated to 32 bits
    assign diff = {center_reg[ALT_W-1], center_reg} - {prev_reg[ALT_W-1], prev_reg};
    always_comb
    begin
        if (diff[ALT_W] != diff[ALT_W-1])
        begin
            rate_sat = diff[ALT_W] ? {1'b1, {(ALT_W-1){1'b0}}}
                                   : {1'b0, {(ALT_W-1){1'b1}}};
        end
        else
        begin
            rate_sat = diff[ALT_W-1:0];
        end
    end
    assign apogee_now = $signed(rate_sat) < $signed({{(ALT_W-THR_W){1'b0}}, thr_reg});

    // Pipeline and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hold_reg <= fused_now;
        end
        if (cmd.sum_en)
        begin
            pair_a_reg <= {win_reg[LO][ALT_W-1], win_reg[LO]}
                        + {win_reg[LO+1][ALT_W-1], win_reg[LO+1]};
            pair_b_reg <= {win_reg[LO+2][ALT_W-1], win_reg[LO+2]}
                        + {win_reg[LO+3][ALT_W-1], win_reg[LO+3]};
        end
        if (cmd.center_en)
        begin
            center_reg <= total[ALT_W+1:2];
        end
        if (cmd.out_plain)
        begin
            fused_out_reg  <= fused_now;
            rate_valid_reg <= 1'b0;
            rate_out_reg   <= '0;
            apogee_reg     <= 1'b0;
        end
        else if (cmd.out_rate)
        begin
            fused_out_reg  <= hold_reg;
            rate_valid_reg <= 1'b1;
            rate_out_reg   <= rate_sat;
            apogee_reg     <= apogee_now;
        end
    end

    // Control state: sample count, previous center, threshold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            prev_reg  <= '0;
            thr_reg   <= THRESHOLD_RESET;
        end
        else
        begin
            if (cmd.load)
            begin
                count_reg <= stat.last_sample ? '0 : count_reg + CNT_W'(1);
            end
            if (cmd.out_rate)
            begin
                prev_reg <= center_reg;
            end
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    assign fused_altitude = fused_out_reg;
    assign rate_valid     = rate_valid_reg;
    assign altitude_rate  = rate_out_reg;
    assign apogee_flag    = apogee_reg;

endmodule

### rtl/apogee_detector_trimmed_median.sv
// ============================================================================
// apogee_detector_trimmed_median: apogee detector, trimmed-median rate
// Fuses barometric and GPS altitude, windows the fused samples and flags
// apogee from the change of the window's trimmed center.
// ============================================================================
// Usage:
//   sample_in  (valid/ready): baro_altitude, gps_altitude, gps_fix.
//   result_out (valid/ready): fused_altitude, rate_valid, altitude_rate,
//   apogee_flag; one result beat per sample beat, in order.
//   cfg_wr_en/cfg_wr_data write apogee_threshold; write only while idle.
// Timing: a sample that does not close the window has its result registered
//   on acceptance, and a new sample is taken every cycle while the result
//   register drains. The sample that closes the window yields its result
//   after WINDOW odd-even sort passes over the sample window, one pairwise
//   add, one center and one rate stage, which waits while the result
//   register is full. No sample is taken before that result is loaded.
// Reset: sample count and previous center clear, threshold returns to 26,
//   no result pending. Window entries are not cleared.
// Stall: a held result stays stable; input ready drops until it is taken.
// ============================================================================
module apogee_detector_trimmed_median #(
    parameter int WINDOW = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    adtm_in_if.sink                    sample_in,
    adtm_out_if.source                 result_out,
    input  logic                       cfg_wr_en,
    input  logic [adtm_pkg::THR_W-1:0] cfg_wr_data
);
    import adtm_pkg::*;

    adtm_cmd_t  cmd;
    adtm_stat_t stat;

    // Sequencer
    adtm_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_in.valid),
        .in_ready  (sample_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath
    adtm_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .baro_altitude  (sample_in.baro_altitude),
        .gps_altitude   (sample_in.gps_altitude),
        .gps_fix        (sample_in.gps_fix),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .fused_altitude (result_out.fused_altitude),
        .rate_valid     (result_out.rate_valid),
        .altitude_rate  (result_out.altitude_rate),
        .apogee_flag    (result_out.apogee_flag)
    );

endmodule
